/* rtl/iuhf_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the IPv4/UDP header framer.
// No dependencies; imported by every module of the block.
package iuhf_pkg;

  localparam int MAX_PACKET_BYTES_DEF = 2048;
  localparam int QUEUE_DEPTH_DEF      = 2;

  localparam logic [4:0]  HDR_BYTES     = 5'd28;
  localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
  localparam logic [7:0]  VER_IHL       = 8'h45;
  localparam logic [15:0] FLAGS_DF      = 16'h4000;
  localparam logic [7:0]  TTL_DEF       = 8'd64;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  // Fixed words of the IPv4 header checksum: 0x4500 + 0x4000 + 0x4011
  localparam logic [18:0] CSUM_BASE     = 19'h0C511;

  // Command kinds passed from front to back
  localparam logic [1:0] CMD_DATA = 2'd0;
  localparam logic [1:0] CMD_HDR  = 2'd1;
  localparam logic [1:0] CMD_OVF  = 2'd2;

  typedef struct packed {
    logic        func;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       status;
  } result_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        last;
    logic [7:0]  data_byte;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] payload_length;
    logic [18:0] raw_sum;
  } cmd_t;

endpackage

/* rtl/iuhf_front.sv */
`timescale 1ns / 1ps
// Front end: accepts items, tracks the open packet and classifies each item.
// Depends on iuhf_pkg.
module iuhf_front import iuhf_pkg::*; #(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_stall,
  input  item_t item,
  input  logic  q_full,
  output logic  push,
  output cmd_t  push_cmd
);

  localparam logic [16:0] MAX_LEN = 17'(MAX_PACKET_BYTES);

  logic        packet_open;
  logic [15:0] payload_left;
  logic        accept;
  logic [16:0] total_len;
  logic        ovf;
  logic        left_one;

  assign item_stall = q_full;
  assign accept     = item_valid && !q_full;
  assign total_len  = {1'b0, item.payload_length} + 17'(HDR_BYTES);
  assign ovf        = total_len > MAX_LEN;
  assign left_one   = payload_left == 16'd1;

  // data with no packet open is dropped
  assign push = accept && !(item.func && !packet_open);

  always_comb begin
    push_cmd                = '0;
    push_cmd.data_byte      = item.data_byte;
    push_cmd.src_addr       = item.src_addr;
    push_cmd.dst_addr       = item.dst_addr;
    push_cmd.src_port       = item.src_port;
    push_cmd.dst_port       = item.dst_port;
    push_cmd.payload_length = item.payload_length;
    push_cmd.raw_sum        = CSUM_BASE + {3'b0, total_len[15:0]}
                            + {3'b0, item.src_addr[31:16]} + {3'b0, item.src_addr[15:0]}
                            + {3'b0, item.dst_addr[31:16]} + {3'b0, item.dst_addr[15:0]};
    if (item.func) begin
      push_cmd.kind = CMD_DATA;
      push_cmd.last = left_one;
    end else if (ovf) begin
      push_cmd.kind = CMD_OVF;
      push_cmd.last = 1'b1;
    end else begin
      push_cmd.kind = CMD_HDR;
      push_cmd.last = item.payload_length == 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_open  <= 1'b0;
      payload_left <= '0;
    end else if (accept) begin
      if (item.func) begin
        if (packet_open) begin
          payload_left <= payload_left - 16'd1;
          packet_open  <= !left_one;
        end
      end else if (ovf) begin
        packet_open  <= 1'b0;
        payload_left <= '0;
      end else begin
        packet_open  <= item.payload_length != 16'd0;
        payload_left <= item.payload_length;
      end
    end
  end

endmodule

/* rtl/iuhf_queue.sv */
`timescale 1ns / 1ps
// Short command queue between front and back ends.
// Depends on iuhf_pkg.
module iuhf_queue import iuhf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic avail,
  output cmd_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = count == CW'(DEPTH);
  assign avail = count != '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* rtl/iuhf_back.sv */
`timescale 1ns / 1ps
// Back end: header byte sequencer, checksum fold and output register.
// Depends on iuhf_pkg.
module iuhf_back import iuhf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    avail,
  input  cmd_t    head,
  output logic    pop,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic        busy;
  logic [4:0]  idx;
  logic        hdr_last;
  logic [31:0] hold_src_addr;
  logic [31:0] hold_dst_addr;
  logic [15:0] hold_src_port;
  logic [15:0] hold_dst_port;
  logic [15:0] total_length_reg;
  logic [15:0] udp_length;
  logic [15:0] header_sum;
  logic        out_load;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [7:0]  hdr_byte;

  assign out_load = !result_valid || !result_stall;
  assign pop      = !busy && avail && out_load;

  // end-around carry fold of the raw checksum sum
  assign fold1 = {1'b0, head.raw_sum[15:0]} + {14'b0, head.raw_sum[18:16]};
  assign fold2 = fold1[15:0] + {15'b0, fold1[16]};

  always_comb begin
    case (idx)
      5'd1, 5'd4, 5'd5, 5'd7,
      5'd26, 5'd27: hdr_byte = 8'h00;
      5'd0:  hdr_byte = VER_IHL;
      5'd2:  hdr_byte = total_length_reg[15:8];
      5'd3:  hdr_byte = total_length_reg[7:0];
      5'd6:  hdr_byte = FLAGS_DF[15:8];
      5'd8:  hdr_byte = TTL_DEF;
      5'd9:  hdr_byte = PROTO_UDP;
      5'd10: hdr_byte = header_sum[15:8];
      5'd11: hdr_byte = header_sum[7:0];
      5'd12: hdr_byte = hold_src_addr[31:24];
      5'd13: hdr_byte = hold_src_addr[23:16];
      5'd14: hdr_byte = hold_src_addr[15:8];
      5'd15: hdr_byte = hold_src_addr[7:0];
      5'd16: hdr_byte = hold_dst_addr[31:24];
      5'd17: hdr_byte = hold_dst_addr[23:16];
      5'd18: hdr_byte = hold_dst_addr[15:8];
      5'd19: hdr_byte = hold_dst_addr[7:0];
      5'd20: hdr_byte = hold_src_port[15:8];
      5'd21: hdr_byte = hold_src_port[7:0];
      5'd22: hdr_byte = hold_dst_port[15:8];
      5'd23: hdr_byte = hold_dst_port[7:0];
      5'd24: hdr_byte = udp_length[15:8];
      5'd25: hdr_byte = udp_length[7:0];
      default: hdr_byte = 8'h00;
    endcase
  end

  // header field holding registers, loaded when a header command is taken
  always_ff @(posedge clk) begin
    if (pop && head.kind == CMD_HDR) begin
      hold_src_addr    <= head.src_addr;
      hold_dst_addr    <= head.dst_addr;
      hold_src_port    <= head.src_port;
      hold_dst_port    <= head.dst_port;
      total_length_reg <= head.payload_length + 16'(HDR_BYTES);
      udp_length       <= head.payload_length + UDP_HDR_BYTES;
      header_sum       <= ~fold2;
      hdr_last         <= head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (out_load) begin
        result_valid <= busy || avail;
      end
      if (busy && out_load) begin
        idx <= idx + 5'd1;
        if (idx == HDR_BYTES - 5'd1) begin
          busy <= 1'b0;
        end
      end else if (pop && head.kind == CMD_HDR) begin
        // byte 0 goes out in the same cycle as the load
        busy <= 1'b1;
        idx  <= 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy && out_load) begin
      result.out_byte <= hdr_byte;
      result.last     <= (idx == HDR_BYTES - 5'd1) && hdr_last;
      result.status   <= 1'b0;
    end else if (pop) begin
      case (head.kind)
        CMD_HDR: begin
          result.out_byte <= VER_IHL;
          result.last     <= 1'b0;
          result.status   <= 1'b0;
        end
        CMD_OVF: begin
          result.out_byte <= 8'h00;
          result.last     <= 1'b1;
          result.status   <= 1'b1;
        end
        default: begin
          result.out_byte <= head.data_byte;
          result.last     <= head.last;
          result.status   <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* rtl/ipv4_udp_header_framer_core.sv */
`timescale 1ns / 1ps
// IPv4/UDP header framer, top level. Depends on iuhf_pkg, iuhf_front, iuhf_queue, iuhf_back.
// Path: an accepted item passes through a queue slot, then the output register.
// Output: a data byte or overflow request gives one result; a start request gives the 28
//   header bytes, stepped out by the back end's byte sequencer. Requests queue meanwhile.
// Reset (rst, synchronous, active high): no packet open, queue empty, no result pending.
module ipv4_udp_header_framer_core import iuhf_pkg::*; #(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF,
  parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  // front -> queue
  logic q_push;
  cmd_t q_push_cmd;
  logic q_full;
  // queue -> back
  logic q_pop;
  logic q_avail;
  cmd_t q_head;

  // Front: owns packet_open and payload_left, so drop / last / overflow are decided
  // at acceptance and the next request can follow as soon as the queue has room. It also
  // forms the raw 19-bit checksum sum of the header words.
  iuhf_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item      (item),
    .q_full    (q_full),
    .push      (q_push),
    .push_cmd  (q_push_cmd)
  );

  // Queue: decouples the front from header emission and output stalls.
  iuhf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_cmd(q_push_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .avail   (q_avail),
    .head    (q_head)
  );

  // Back: folds the checksum, walks the 28 header bytes, passes payload bytes and
  // overflow results, and holds the output register.
  iuhf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .avail       (q_avail),
    .head        (q_head),
    .pop         (q_pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule

/* rtl/iuhf_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the framer, bound to the top level.
// Depends on iuhf_pkg and ipv4_udp_header_framer_core.
module iuhf_checker import iuhf_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_stall,
  input item_t   item,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_stall |=> item_valid && $stable(item))
    else $error("stalled request changed");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_ovf_form: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status |-> result.last && result.out_byte == 8'h00)
    else $error("overflow result malformed");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  a_reset_ready: assert property (@(posedge clk)
    rst |=> !item_stall)
    else $error("input stalled after reset");

endmodule

bind ipv4_udp_header_framer_core iuhf_checker u_iuhf_checker (.*);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for ipv4_udp_header_framer_core: drives start and payload
// requests, predicts the framed header and payload bytes, and checks each result.
// Depends on iuhf_pkg (item_t, result_t, header constants) and the core RTL.
module tb_top;
  import iuhf_pkg::*;

  localparam int PKT_LIMIT   = 2048;
  localparam int LAT_TAIL    = 40;      // extra cycles after the last expected byte
  localparam int CYCLE_LIMIT = 200000;  // far above the slowest legal run

  // Request kinds and status codes as seen on the ports
  localparam logic FUNC_START      = 1'b0;
  localparam logic FUNC_DATA       = 1'b1;
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_OVERFLOW = 1'b1;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

  logic    clk = 1'b0;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  ipv4_udp_header_framer_core #(.MAX_PACKET_BYTES(PKT_LIMIT)) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #2 clk = ~clk;

  // Predictor state: mirrors the framer's open packet and remaining payload
  logic        pkt_open;
  logic [15:0] bytes_left;
  result_t     pending_bytes[$];  // framed bytes not yet seen on the output

  int fail_count = 0;
  int cycle_count = 0;
  int burst_left = 0;

  // Appends one expected byte at the tail of the expectation queue
  function automatic void queue_result(input result_t r);
    pending_bytes = {pending_bytes, r};
  endfunction

  // Ones'-complement checksum (complement of the sum) over the 20-byte IPv4 header, checksum word taken as 0
  function automatic logic [15:0] ip_header_checksum(input logic [15:0] tot_len,
                                                     input logic [31:0] src,
                                                     input logic [31:0] dst);
    logic [31:0] acc;
    acc = {VER_IHL, 8'h00} + tot_len + FLAGS_DF + {TTL_DEF, PROTO_UDP}
        + src[31:16] + src[15:0] + dst[31:16] + dst[15:0];
    acc = acc[15:0] + acc[31:16];
    acc = acc[15:0] + acc[31:16];
    return ~acc[15:0];
  endfunction

  // Works out the bytes one accepted request causes and queues them
  function automatic void frame_request(input item_t req);
    logic [15:0]  tot_len;
    logic [223:0] hdr;
    result_t      r;
    if (req.func == FUNC_DATA) begin
      if (!pkt_open) return;  // stray payload byte is dropped
      bytes_left = bytes_left - 16'd1;
      if (bytes_left == 16'd0) pkt_open = 1'b0;
      r.out_byte = req.data_byte;
      r.last     = (bytes_left == 16'd0);
      r.status   = STATUS_OK;
      queue_result(r);
      return;
    end
    if (int'(req.payload_length) + 28 > PKT_LIMIT) begin
      // too long: one error byte, any open packet is closed
      pkt_open   = 1'b0;
      bytes_left = 16'd0;
      r.out_byte = 8'h00;
      r.last     = 1'b1;
      r.status   = STATUS_OVERFLOW;
      queue_result(r);
      return;
    end
    tot_len    = req.payload_length + 16'd28;
    bytes_left = req.payload_length;
    pkt_open   = (req.payload_length != 16'd0);
    hdr = {VER_IHL, 8'h00, tot_len, 16'h0000, FLAGS_DF, TTL_DEF, PROTO_UDP,
           ip_header_checksum(tot_len, req.src_addr, req.dst_addr),
           req.src_addr, req.dst_addr, req.src_port, req.dst_port,
           req.payload_length + UDP_HDR_BYTES, 16'h0000};
    for (int i = 0; i < 28; i++) begin
      r.out_byte = hdr[223 - 8*i -: 8];
      r.last     = (i == 27) && (req.payload_length == 16'd0);
      r.status   = STATUS_OK;
      queue_result(r);
    end
  endfunction

  function automatic item_t start_request(input logic [31:0] src, input logic [31:0] dst,
                                          input logic [15:0] sport, input logic [15:0] dport,
                                          input logic [15:0] plen);
    item_t r;
    r.func           = FUNC_START;
    r.src_addr       = src;
    r.dst_addr       = dst;
    r.src_port       = sport;
    r.dst_port       = dport;
    r.payload_length = plen;
    r.data_byte      = 8'($urandom());  // ignored on a start
    return r;
  endfunction

  function automatic item_t rand_start(input logic [15:0] plen);
    return start_request($urandom(), $urandom(), 16'($urandom()), 16'($urandom()), plen);
  endfunction

  // Payload request; every field but data_byte is noise the block must ignore
  function automatic item_t data_request(input logic [7:0] b);
    item_t r;
    r.func           = FUNC_DATA;
    r.src_addr       = $urandom();
    r.dst_addr       = $urandom();
    r.src_port       = 16'($urandom());
    r.dst_port       = 16'($urandom());
    r.payload_length = 16'($urandom());
    r.data_byte      = b;
    return r;
  endfunction

  // Sends one request: entered and left at a falling edge. The sender runs in
  // bursts; between bursts valid may drop for a random gap.
  task automatic send_request(input item_t req);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    item       <= req;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    frame_request(req);
    @(negedge clk);
  endtask

  // Holds the sender off until every expected byte has come out
  task automatic drain_results();
    item_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(negedge clk);
  endtask

  // Stray payload before any packet, empty packet, extreme field values
  task automatic test_header_extremes();
    send_request(data_request(8'h5a));
    send_request(start_request(32'h0, 32'h0, 16'h0, 16'h0, 16'd0));
    send_request(data_request(8'h33));  // packet already closed by empty payload
    send_request(start_request(32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff, 16'd1));
    send_request(data_request(8'hff));
    send_request(start_request(32'hc0a8_0001, 32'h0a00_0002, 16'd1234, 16'd80, 16'd3));
    send_request(data_request(8'h00));
    send_request(data_request(8'h80));
    send_request(data_request(8'h01));
  endtask

  // Largest legal length abandoned by a new start, overflow at the boundary
  // and at the field maximum, overflow closing an open packet
  task automatic test_abandon_and_overflow();
    send_request(rand_start(16'(PKT_LIMIT - 28)));
    send_request(data_request(8'h11));
    send_request(data_request(8'h22));
    send_request(rand_start(16'd2));
    send_request(data_request(8'haa));
    send_request(data_request(8'h55));
    send_request(rand_start(16'(PKT_LIMIT - 27)));
    send_request(data_request(8'h44));
    send_request(rand_start(16'hffff));
    send_request(rand_start(16'd4));
    send_request(data_request(8'h0f));
    send_request(data_request(8'hf0));
    send_request(rand_start(16'hf000));
    send_request(data_request(8'h77));  // dropped: overflow closed the packet
  endtask

  // Payload resumes after the output has fully drained mid-packet
  task automatic test_drain_pause();
    send_request(rand_start(16'd2));
    drain_results();
    send_request(data_request(8'h3c));
    send_request(data_request(8'hc3));
  endtask

  // Mostly well-formed packets with random content; some cut short by a new
  // start, some overflow starts, some stray bytes while no packet is open
  task automatic test_random_packets();
    int sent;
    int plen;
    int cut;
    int pick;
    sent = 0;
    while (sent < 255) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        plen = $urandom_range(0, 7) == 0 ? $urandom_range(17, 48) : $urandom_range(0, 16);
        send_request(rand_start(16'(plen)));
        sent++;
        cut = $urandom_range(0, 9) == 0 ? $urandom_range(0, plen) : plen;
        for (int i = 0; i < cut; i++) begin
          send_request(data_request(8'($urandom())));
          sent++;
        end
      end else if (pick == 8) begin
        send_request(rand_start(16'($urandom_range(PKT_LIMIT - 27, 65535))));
        sent++;
      end else if (!pkt_open) begin
        send_request(data_request(8'($urandom())));
      end
    end
  endtask

  // Receiver stall pattern, independent of the sender
  rx_mode_e rx_mode = RX_FREE;
  int       rx_phase_left = 0;

  always @(negedge clk) begin
    if (rx_phase_left == 0) begin
      rx_mode       = rx_mode_e'($urandom_range(0, 3));
      rx_phase_left = $urandom_range(8, 60);
    end
    rx_phase_left--;
    case (rx_mode)
      RX_FREE:  result_stall <= 1'b0;
      RX_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
      default:  result_stall <= rx_phase_left[2];
    endcase
  end

  // Result checker: each accepted byte against the oldest expectation
  always @(posedge clk) begin : check_result
    result_t due;
    if (!rst && result_valid && !result_stall) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected result: out_byte %0h last %0b status %0b",
               result.out_byte, result.last, result.status);
        fail_count++;
      end else begin
        due = pending_bytes.pop_front();
        if (result.out_byte !== due.out_byte) begin
          $error("out_byte: expected %0h, got %0h", due.out_byte, result.out_byte);
          fail_count++;
        end
        if (result.last !== due.last) begin
          $error("last: expected %0b, got %0b", due.last, result.last);
          fail_count++;
        end
        if (result.status !== due.status) begin
          $error("status: expected %0b, got %0b", due.status, result.status);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    pkt_open     = 1'b0;
    bytes_left   = 16'd0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_header_extremes();
    test_abandon_and_overflow();
    test_drain_pause();
    test_random_packets();

    drain_results();
    repeat (LAT_TAIL) @(negedge clk);
    if (fail_count == 0 && pending_bytes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
